[design/pit3_pkg.sv]
// Package for the three-channel interval timer: item types, kinds and access codes.
// No dependencies.
package pit3_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_CMD   = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LOW   = 2'd1;
   localparam logic [1:0] ACC_HIGH  = 2'd2;
   localparam logic [1:0] ACC_BOTH  = 2'd3;

   localparam logic [2:0] MODE_INT   = 3'd0;
   localparam logic [2:0] MODE_ONE   = 3'd1;
   localparam logic [2:0] MODE_RATE  = 3'd2;
   localparam logic [2:0] MODE_SQR   = 3'd3;
   localparam logic [2:0] MODE_STRB  = 3'd4;
   localparam logic [2:0] MODE_HSTRB = 3'd5;

   localparam logic [7:0] ABSENT_READ = 8'hFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] channel;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_ch0;
      logic       out_ch1;
      logic       out_ch2;
      logic       irq_rise;
   } rsp_type;

endpackage

[design/interval_timer_three_channel.sv]
// Three-channel interval timer top level.
// The result item is registered in the cycle after the item is accepted.
// Throughput: one item per cycle; the result register updates whenever it
// is empty or being taken, so a new item enters in every cycle unless a
// waiting result is held off by rsp_stall, which stalls the input.
// Reset: synchronous, clears all counter state (outputs high, access low then
// high) and empties the result register.
module interval_timer_three_channel
   import pit3_pkg::*;
#(
   parameter int NUM_COUNTERS = 3,
   parameter int COUNT_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CB = COUNT_BITS;
   localparam int NC = NUM_COUNTERS;

   logic [CB-1:0] reload_ff   [NC], reload_in   [NC];
   logic [CB-1:0] live_ff     [NC], live_in     [NC];
   logic [CB-1:0] latched_ff  [NC], latched_in  [NC];
   logic [1:0]    acc_ff      [NC], acc_in      [NC];
   logic [2:0]    mode_ff     [NC], mode_in     [NC];
   logic [7:0]    plow_ff     [NC], plow_in     [NC];
   logic [NC-1:0] held_ff, held_in, rhi_ff, rhi_in, whi_ff, whi_in;
   logic [NC-1:0] lvl_ff, lvl_in, cnt_ff, cnt_in, pend_ff, pend_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Mode 3 load for the half period starting at the given level.
   function automatic logic [CB-1:0] sq_load(input logic [CB-1:0] n, input logic lvl);
      if (n[0] && lvl) sq_load = n + CB'(1);
      else             sq_load = {n[CB-1:1], 1'b0};
   endfunction

   // Align a 16-bit written value to the counter width.
   function automatic logic [CB-1:0] fit(input logic [15:0] v);
      fit = v[CB-1:0];
   endfunction

   always_comb begin
      logic [1:0]    cc, ca;
      logic [2:0]    cm;
      logic [CB-1:0] v, dec;
      logic [15:0]   wv;
      logic          wdone;
      logic [7:0]    rd;
      logic          lvl0_prev;
      cc = req_data.data_byte[7:6];
      ca = req_data.data_byte[5:4];
      cm = req_data.data_byte[3:1];
      if (cm[2:1] == 2'b11) cm = {1'b0, cm[1:0]};
      rd = 8'd0;
      v = '0; dec = '0; wv = '0; wdone = 1'b0;
      lvl0_prev = lvl_ff[0];
      reload_in = reload_ff; live_in = live_ff; latched_in = latched_ff;
      acc_in = acc_ff; mode_in = mode_ff; plow_in = plow_ff;
      held_in = held_ff; rhi_in = rhi_ff; whi_in = whi_ff;
      lvl_in = lvl_ff; cnt_in = cnt_ff; pend_in = pend_ff;
      if ((req_data.kind == KIND_READ || req_data.kind == KIND_WRITE)
          && 32'(req_data.channel) >= NC && req_data.kind == KIND_READ)
         rd = ABSENT_READ;
      for (int c = 0; c < NC; c++) begin
         case (req_data.kind)
            KIND_TICK: begin
               if (mode_ff[c] == MODE_STRB && !lvl_ff[c]) lvl_in[c] = 1'b1;
               if (mode_ff[c] != MODE_ONE && mode_ff[c] != MODE_HSTRB) begin
                  if (pend_ff[c] && (mode_ff[c] == MODE_INT || mode_ff[c] == MODE_STRB
                                     || !cnt_ff[c])) begin
                     pend_in[c] = 1'b0;
                     cnt_in[c]  = 1'b1;
                     live_in[c] = (mode_ff[c] == MODE_SQR)
                                  ? sq_load(reload_ff[c], lvl_ff[c]) : reload_ff[c];
                  end else if (cnt_ff[c]) begin
                     dec = live_ff[c] - CB'(1);
                     case (mode_ff[c])
                        MODE_INT: begin
                           live_in[c] = dec;
                           if (dec == '0) lvl_in[c] = 1'b1;
                        end
                        MODE_RATE: begin
                           if (!lvl_ff[c]) begin
                              lvl_in[c] = 1'b1;
                              live_in[c] = reload_ff[c];
                              pend_in[c] = 1'b0;
                           end else begin
                              live_in[c] = dec;
                              if (dec == CB'(1)) lvl_in[c] = 1'b0;
                           end
                        end
                        MODE_SQR: begin
                           v = live_ff[c] - CB'(2);
                           live_in[c] = v;
                           if (v == '0) begin
                              lvl_in[c] = ~lvl_ff[c];
                              pend_in[c] = 1'b0;
                              live_in[c] = sq_load(reload_ff[c], ~lvl_ff[c]);
                           end
                        end
                        default: begin
                           live_in[c] = dec;
                           if (dec == '0) begin
                              lvl_in[c] = 1'b0;
                              cnt_in[c] = 1'b0;
                           end
                        end
                     endcase
                  end
               end
            end
            KIND_CMD: begin
               if (32'(cc) == c) begin
                  if (ca == ACC_LATCH) begin
                     if (!held_ff[c]) begin
                        latched_in[c] = live_ff[c];
                        held_in[c] = 1'b1;
                     end
                  end else begin
                     acc_in[c] = ca;
                     mode_in[c] = cm;
                     rhi_in[c] = 1'b0; whi_in[c] = 1'b0; held_in[c] = 1'b0;
                     cnt_in[c] = 1'b0; pend_in[c] = 1'b0;
                     lvl_in[c] = (cm != MODE_INT);
                  end
               end
            end
            KIND_WRITE: begin
               if (32'(req_data.channel) == c) begin
                  wdone = 1'b0;
                  case (acc_ff[c])
                     ACC_LOW: begin
                        wv = {8'd0, req_data.data_byte}; wdone = 1'b1;
                     end
                     ACC_HIGH: begin
                        wv = {req_data.data_byte, 8'd0}; wdone = 1'b1;
                     end
                     default: begin
                        if (!whi_ff[c]) begin
                           plow_in[c] = req_data.data_byte;
                           whi_in[c] = 1'b1;
                           if (mode_ff[c] == MODE_INT) cnt_in[c] = 1'b0;
                        end else begin
                           whi_in[c] = 1'b0;
                           wv = {req_data.data_byte, plow_ff[c]};
                           wdone = 1'b1;
                        end
                     end
                  endcase
                  if (wdone) begin
                     reload_in[c] = fit(wv);
                     if (mode_ff[c] == MODE_INT) begin
                        lvl_in[c] = 1'b0; pend_in[c] = 1'b1;
                     end else if (mode_ff[c] == MODE_STRB) begin
                        lvl_in[c] = 1'b1; pend_in[c] = 1'b1;
                     end else if (mode_ff[c] == MODE_RATE || mode_ff[c] == MODE_SQR) begin
                        pend_in[c] = 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (32'(req_data.channel) == c) begin
                  wv = 16'(held_ff[c] ? latched_ff[c] : live_ff[c]);
                  case (acc_ff[c])
                     ACC_LOW: begin
                        rd = wv[7:0]; held_in[c] = 1'b0;
                     end
                     ACC_HIGH: begin
                        rd = wv[15:8]; held_in[c] = 1'b0;
                     end
                     default: begin
                        if (!rhi_ff[c]) begin
                           rd = wv[7:0]; rhi_in[c] = 1'b1;
                        end else begin
                           rd = wv[15:8]; rhi_in[c] = 1'b0; held_in[c] = 1'b0;
                        end
                     end
                  endcase
               end
            end
         endcase
      end
      rsp_in.read_data = rd;
      rsp_in.out_ch0   = lvl_in[0];
      rsp_in.out_ch1   = (NC > 1) ? lvl_in[(NC > 1) ? 1 : 0] : 1'b0;
      rsp_in.out_ch2   = (NC > 2) ? lvl_in[(NC > 2) ? 2 : 0] : 1'b0;
      rsp_in.irq_rise  = ~lvl0_prev & lvl_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff <= '0; rhi_ff <= '0; whi_ff <= '0;
         lvl_ff <= '1; cnt_ff <= '0; pend_ff <= '0;
         for (int c = 0; c < NC; c++) begin
            reload_ff[c] <= '0; live_ff[c] <= '0; latched_ff[c] <= '0;
            acc_ff[c] <= ACC_BOTH; mode_ff[c] <= MODE_INT; plow_ff[c] <= '0;
         end
      end else begin
         if (!req_stall) rsp_valid_ff <= req_valid;
         if (take) begin
            rsp_ff <= rsp_in;
            reload_ff <= reload_in; live_ff <= live_in; latched_ff <= latched_in;
            acc_ff <= acc_in; mode_ff <= mode_in; plow_ff <= plow_in;
            held_ff <= held_in; rhi_ff <= rhi_in; whi_ff <= whi_in;
            lvl_ff <= lvl_in; cnt_ff <= cnt_in; pend_ff <= pend_in;
         end
      end
   end

endmodule
